// ===== hw/rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_CMP = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_ZDEN = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] left_num;
        logic [30:0]        left_den;
        logic signed [31:0] right_num;
        logic [30:0]        right_den;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_num;
        logic [30:0]        result_den;
        logic [1:0]         status;
        logic [1:0]         order;
    } t_out;

    // start strobe from the sequencer to an iterative unit (done is a separate port)
    typedef struct packed {
        logic start;
    } t_ctl;

endpackage

// ===== hw/rtl/rau_mul.sv =====
// ----------------------------------------------------------------------------
// rau_mul
// Registered 33x33 signed multiplier, low 64 bits of the product.
// ----------------------------------------------------------------------------
module rau_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [63:0] o_p
);
    logic signed [65:0] w_full;

    assign w_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        o_p <= w_full[63:0];
    end
endmodule

// ===== hw/rtl/rau_gcd.sv =====
// ----------------------------------------------------------------------------
// rau_gcd
// Binary GCD, one shift or subtract step per cycle.
// ----------------------------------------------------------------------------
module rau_gcd (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rau_pkg::t_ctl i_ctl,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output logic          o_done,
    output logic [63:0]   o_g
);
    logic [63:0] r_a, r_b, n_a, n_b;
    logic [6:0]  r_k, n_k;
    logic        r_busy;
    logic        w_fin;

    assign w_fin = (r_a == 64'd0) || (r_b == 64'd0);

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_k = r_k;
        priority if (!r_a[0] && !r_b[0]) begin
            n_a = r_a >> 1;
            n_b = r_b >> 1;
            n_k = r_k + 7'd1;
        end else if (!r_a[0]) begin
            n_a = r_a >> 1;
        end else if (!r_b[0]) begin
            n_b = r_b >> 1;
        end else if (r_a >= r_b) begin
            n_a = r_a - r_b;
        end else begin
            n_b = r_b - r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= !i_ctl.start && r_busy && w_fin;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_fin) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_k <= 7'd0;
        end else if (r_busy && w_fin) begin
            o_g <= (r_a | r_b) << r_k;
        end else if (r_busy) begin
            r_a <= n_a;
            r_b <= n_b;
            r_k <= n_k;
        end
    end
endmodule

// ===== hw/rtl/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div
// Restoring divider, 64-bit unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rau_pkg::t_ctl i_ctl,
    input  logic [63:0]   i_n,
    input  logic [63:0]   i_d,
    output logic          o_done,
    output logic [63:0]   o_q
);
    logic [63:0] r_rem;
    logic [64:0] w_t, w_sub;
    logic [63:0] r_q, r_d;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        w_ge;

    assign w_t   = {r_rem, r_q[63]};
    assign w_sub = w_t - {1'b0, r_d};
    assign w_ge  = w_t >= {1'b0, r_d};
    assign o_q   = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            o_done <= !i_ctl.start && r_busy && (r_cnt == 7'd63);
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= 64'd0;
            r_q   <= i_n;
            r_d   <= i_d;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[63:0] : w_t[63:0];
            r_q   <= {r_q[62:0], w_ge};
        end
    end
endmodule

// ===== hw/rtl/rational_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Add, subtract, multiply, divide or compare two signed fractions, with the
// result reduced by its GCD and the denominator kept positive.
// ----------------------------------------------------------------------------
// One word at a time. A word is taken when start is high and busy is low;
// busy then stays high until the result word has been shown on o_out for one
// cycle with o_valid high. The receiver cannot stall: sample o_out whenever
// o_valid is high. Words rejected up front (zero denominator, division by a
// zero fraction, unused command) go straight to the result state; compare
// stops after the cross products. Arithmetic also runs the binary GCD. The
// three cross products share one multiplier, and the shared 64-bit serial
// divider runs twice to divide numerator and denominator by the GCD. WIDTH
// sets the overflow limits only; the ports are always at full field width.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core #(
    parameter int WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rau_pkg::t_in  i_in,
    output logic          o_valid,
    output rau_pkg::t_out o_out
);
    localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_M0   = 13'b0000000000010,
        S_M1   = 13'b0000000000100,
        S_M2   = 13'b0000000001000,
        S_M3   = 13'b0000000010000,
        S_PREP = 13'b0000000100000,
        S_GST  = 13'b0000001000000,
        S_GCD  = 13'b0000010000000,
        S_DNS  = 13'b0000100000000,
        S_DN   = 13'b0001000000000,
        S_DDS  = 13'b0010000000000,
        S_DD   = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } t_state;

    t_state r_state;
    rau_pkg::t_in r_in;
    rau_pkg::t_ctl w_gctl, w_dctl;

    logic signed [32:0] w_ln, w_rn, w_ld, w_rd, w_ma, w_mb;
    logic signed [63:0] w_p, r_p0, r_p1;
    logic signed [63:0] w_n, w_d;
    logic [63:0] r_mag, r_d, r_g, r_qn, w_g, w_q;
    logic        r_neg, w_gdone, w_ddone, w_ovf;
    logic [31:0] w_num;

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

    // sign or zero extend operands to the shared 33-bit multiplier
    assign w_ln = {r_in.left_num[31], r_in.left_num};
    assign w_rn = {r_in.right_num[31], r_in.right_num};
    assign w_ld = {2'b00, r_in.left_den};
    assign w_rd = {2'b00, r_in.right_den};

    // product order: P0 in M0, P1 in M1, P2 (den product) in M2
    always_comb begin
        w_ma = w_ld;
        w_mb = w_rd;
        unique case (r_state)
            S_M0: begin
                w_ma = w_ln;
                w_mb = (r_in.command == rau_pkg::CMD_MUL) ? w_rn : w_rd;
            end
            S_M1: begin
                w_ma = (r_in.command == rau_pkg::CMD_MUL) ? w_ld : w_rn;
                w_mb = (r_in.command == rau_pkg::CMD_MUL) ? w_rd : w_ld;
            end
            default: begin
                w_ma = w_ld;
                w_mb = w_rd;
            end
        endcase
    end

    rau_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    // P2 sits on the multiplier output during PREP
    always_comb begin
        w_n = r_p0;
        w_d = r_p1;
        unique case (r_in.command)
            rau_pkg::CMD_ADD: begin
                w_n = r_p0 + r_p1;
                w_d = w_p;
            end
            rau_pkg::CMD_SUB: begin
                w_n = r_p0 - r_p1;
                w_d = w_p;
            end
            rau_pkg::CMD_DIV: begin
                // negative divisor: sign moves to the numerator
                w_n = r_p1[63] ? -r_p0 : r_p0;
                w_d = r_p1[63] ? -r_p1 : r_p1;
            end
            default: begin
                w_n = r_p0;
                w_d = r_p1;
            end
        endcase
    end

    assign w_gctl.start = (r_state == S_GST);
    assign w_dctl.start = (r_state == S_DNS) || (r_state == S_DDS);

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_gctl),
        .i_a     (r_mag),
        .i_b     (r_d),
        .o_done  (w_gdone),
        .o_g     (w_g)
    );

    rau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dctl),
        .i_n     ((r_state == S_DNS) ? r_mag : r_d),
        .i_d     (r_g),
        .o_done  (w_ddone),
        .o_q     (w_q)
    );

    // w_q is the reduced denominator in DD, r_qn the reduced magnitude
    assign w_ovf = (w_q > LIM - 64'd1) ||
                   (r_neg ? (r_qn > LIM) : (r_qn > LIM - 64'd1));
    assign w_num = r_neg ? (32'd0 - r_qn[31:0]) : r_qn[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (i_in.left_den == 31'd0 || i_in.right_den == 31'd0 ||
                            i_in.command > rau_pkg::CMD_CMP ||
                            (i_in.command == rau_pkg::CMD_DIV &&
                             i_in.right_num == 32'sd0)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_M0;
                        end
                    end
                end
                S_M0:   r_state <= S_M1;
                S_M1:   r_state <= S_M2;
                S_M2:   r_state <= S_M3;
                S_M3:   r_state <= S_PREP;
                S_PREP: r_state <= (r_in.command == rau_pkg::CMD_CMP) ? S_DONE : S_GST;
                S_GST:  r_state <= S_GCD;
                S_GCD:  if (w_gdone) r_state <= S_DNS;
                S_DNS:  r_state <= S_DN;
                S_DN:   if (w_ddone) r_state <= S_DDS;
                S_DDS:  r_state <= S_DD;
                S_DD:   if (w_ddone) r_state <= S_DONE;
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_in <= i_in;
            o_out.result_num <= 32'sd0;
            o_out.result_den <= 31'd1;
            o_out.order      <= rau_pkg::ORD_LESS;
            if (i_in.left_den == 31'd0 || i_in.right_den == 31'd0) begin
                o_out.status <= rau_pkg::ST_ZDEN;
            end else if (i_in.command == rau_pkg::CMD_DIV &&
                         i_in.right_num == 32'sd0) begin
                o_out.status <= rau_pkg::ST_DIVZ;
            end else begin
                o_out.status <= rau_pkg::ST_OK;
            end
        end
        if (r_state == S_M1) r_p0 <= w_p;
        if (r_state == S_M2) r_p1 <= w_p;
        if (r_state == S_PREP) begin
            // compare uses P0 and P1 as the two cross products
            if (r_in.command != rau_pkg::CMD_CMP) begin
                o_out.order <= rau_pkg::ORD_LESS;
            end else if (r_p0 < r_p1) begin
                o_out.order <= rau_pkg::ORD_LESS;
            end else if (r_p0 == r_p1) begin
                o_out.order <= rau_pkg::ORD_EQUAL;
            end else begin
                o_out.order <= rau_pkg::ORD_GREATER;
            end
            r_neg <= (r_in.command == rau_pkg::CMD_CMP) ? 1'b0 : w_n[63];
            r_mag <= w_n[63] ? (64'd0 - w_n) : w_n;
            r_d   <= w_d;
        end
        if (r_state == S_GCD && w_gdone) r_g <= w_g;
        if (r_state == S_DN && w_ddone) r_qn <= w_q;
        if (r_state == S_DD && w_ddone) begin
            if (w_ovf) begin
                o_out.status <= rau_pkg::ST_OVF;
            end else begin
                o_out.result_num <= w_num;
                o_out.result_den <= w_q[30:0];
            end
        end
    end

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.status != rau_pkg::ST_OK) |->
        (o_out.result_num == 32'sd0 && o_out.result_den == 31'd1))
        else $error("error result is not 0/1");

    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.result_den != 31'd0))
        else $error("zero result denominator");

    a_gcd_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GCD && w_gdone) |-> (w_g != 64'd0))
        else $error("gcd returned zero");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rational arithmetic unit: directed corner words,
// then random fractions under several idle phases, checked against a local
// exact predictor with GCD reduction.
// ----------------------------------------------------------------------------
module tb;

    localparam int WIDTH = 32;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    rau_pkg::t_in  i_in = '0;
    logic o_valid;
    rau_pkg::t_out o_out;

    rational_arithmetic_unit_core #(.WIDTH(WIDTH)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_in(i_in), .o_valid(o_valid), .o_out(o_out)
    );

    always #2 i_clk = ~i_clk;

    rau_pkg::t_in  pending_words[$];
    rau_pkg::t_out expected_results[$];
    int   idle_pct = 0;       // sender idle chance per cycle
    bit   hold_off = 1'b0;    // pause sender until all results are in
    bit   stim_done = 1'b0;
    int   fail_count = 0;

    function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // reduce n/d (d > 0) into r, flag overflow against WIDTH limits
    function automatic void reduce_frac(longint n, longint d, inout rau_pkg::t_out r);
        bit neg;
        longint unsigned mag, ud, lim, g;
        neg = n < 0;
        mag = neg ? -n : n;
        ud = d;
        lim = 64'd1 << (WIDTH - 1);
        g = gcd64(mag, ud);
        mag = mag / g;
        ud = ud / g;
        if (ud > lim - 1 || (neg ? mag > lim : mag > lim - 1)) begin
            r.status = rau_pkg::ST_OVF;
        end else begin
            r.result_num = 32'(neg ? -mag : mag);
            r.result_den = ud[30:0];
        end
    endfunction

    function automatic rau_pkg::t_out predict_rational(rau_pkg::t_in w);
        rau_pkg::t_out r;
        longint ln, ld, rn, rd, n, d;
        r = '0;
        r.result_den = 31'd1;
        ln = w.left_num;
        ld = longint'(w.left_den);
        rn = w.right_num;
        rd = longint'(w.right_den);
        if (ld == 0 || rd == 0) begin
            r.status = rau_pkg::ST_ZDEN;
        end else begin
            case (w.command)
                rau_pkg::CMD_ADD: reduce_frac(ln * rd + rn * ld, ld * rd, r);
                rau_pkg::CMD_SUB: reduce_frac(ln * rd - rn * ld, ld * rd, r);
                rau_pkg::CMD_MUL: reduce_frac(ln * rn, ld * rd, r);
                rau_pkg::CMD_DIV: begin
                    if (rn == 0) begin
                        r.status = rau_pkg::ST_DIVZ;
                    end else begin
                        n = ln * rd;
                        d = ld * rn;
                        if (d < 0) begin
                            n = -n;
                            d = -d;
                        end
                        reduce_frac(n, d, r);
                    end
                end
                rau_pkg::CMD_CMP: begin
                    n = ln * rd;
                    d = rn * ld;
                    r.order = (n < d) ? rau_pkg::ORD_LESS :
                              ((n == d) ? rau_pkg::ORD_EQUAL : rau_pkg::ORD_GREATER);
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // driver: start stays high while a word waits, hold_off is clear and the idle roll allows
    always @(posedge i_clk) begin
        if (start && !busy) begin
            expected_results.push_back(predict_rational(i_in));
            void'(pending_words.pop_front());
        end
        if (pending_words.size() > 0 && !hold_off &&
            ($urandom_range(99) >= idle_pct)) begin
            start <= 1'b1;
            i_in  <= pending_words[0];
        end else begin
            start <= 1'b0;
        end
    end

    // pop is done above only on acceptance, so the head stays until taken
    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_out);
                fail_count++;
            end else begin
                rau_pkg::t_out e;
                e = expected_results.pop_front();
                if (o_out.result_num !== e.result_num || o_out.result_den !== e.result_den
                    || o_out.status !== e.status || o_out.order !== e.order) begin
                    $display("%0t: mismatch expected %0d/%0d st %0d ord %0d, got %0d/%0d st %0d ord %0d",
                             $time, e.result_num, e.result_den, e.status, e.order,
                             o_out.result_num, o_out.result_den, o_out.status, o_out.order);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_num();
        case ($urandom_range(5))
            0: return $urandom_range(20) - 10;
            1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            2: return $urandom_range(2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_den();
        case ($urandom_range(6))
            0: return 31'd0;
            1: return 31'($urandom_range(12));
            2: return 31'h7fff_ffff;
            3: return 31'($urandom_range(1000));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic rau_pkg::t_in make_word(logic [2:0] c, logic [31:0] ln,
                                               logic [30:0] ld, logic [31:0] rn,
                                               logic [30:0] rd);
        rau_pkg::t_in w;
        w.command = c;
        w.left_num = ln;
        w.left_den = ld;
        w.right_num = rn;
        w.right_den = rd;
        return w;
    endfunction

    task automatic drain();
        wait (pending_words.size() == 0 && expected_results.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int phase_pct[4] = '{0, 69, 0, 26};
        logic [2:0] c;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        for (int k = 0; k < 5; k++) begin
            c = k[2:0];
            pending_words.push_back(make_word(c, 32'sd1, 31'd2, 32'sd1, 31'd3));
            pending_words.push_back(make_word(c, 32'h8000_0000, 31'h7fff_ffff,
                                              32'h7fff_ffff, 31'd1));
        end
        pending_words.push_back(make_word(rau_pkg::CMD_ADD, 32'sd1, 31'd0, 32'sd1, 31'd1));
        pending_words.push_back(make_word(rau_pkg::CMD_CMP, 32'sd1, 31'd1, 32'sd1, 31'd0));
        pending_words.push_back(make_word(rau_pkg::CMD_DIV, 32'sd5, 31'd7, 32'sd0, 31'd3));
        pending_words.push_back(make_word(rau_pkg::CMD_DIV, 32'sd3, 31'd4, -32'sd5, 31'd6));
        pending_words.push_back(make_word(rau_pkg::CMD_SUB, 32'sd2, 31'd3, 32'sd2, 31'd3));
        pending_words.push_back(make_word(rau_pkg::CMD_MUL, 32'h8000_0000, 31'd1,
                                          32'h8000_0000, 31'd1));
        pending_words.push_back(make_word(rau_pkg::CMD_CMP, 32'sd2, 31'd4, 32'sd1, 31'd2));
        pending_words.push_back(make_word(3'd5, 32'sd1, 31'd1, 32'sd1, 31'd1));
        pending_words.push_back(make_word(3'd7, -32'sd1, 31'd9, 32'sd4, 31'd2));
        pending_words.push_back(make_word(rau_pkg::CMD_DIV, 32'h7fff_ffff, 31'd1,
                                          32'sd1, 31'h7fff_ffff));
        drain();

        // random phases; each pauses the sender with hold_off partway through, then drains
        for (int p = 0; p < 4; p++) begin
            idle_pct = phase_pct[p];
            for (int k = 0; k < 375; k++) begin
                c = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 5))
                                              : 3'($urandom_range(4));
                pending_words.push_back(make_word(c, rand_num(), rand_den(),
                                                  rand_num(), rand_den()));
            end
            wait (pending_words.size() < 300);
            hold_off = 1'b1;
            wait (expected_results.size() == 0);
            repeat (3) @(posedge i_clk);
            hold_off = 1'b0;
            drain();
        end
        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #12000000;
        $display("status: fail");
        $finish;
    end
endmodule
